### rtl/slm_pkg.sv
// Package for the sorted list merge block: sizes, request and status codes,
// and the point and memory request types. No dependencies.
package slm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int KEY_W      = 64;
    localparam int VALUE_W    = 64;
    localparam int POINT_W    = KEY_W + VALUE_W;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MERGE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_POINT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [KEY_W-1:0]   key;
    } point_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
        point_t           wdata;
    } ram_req_t;

    typedef enum logic {
        S_IDLE,
        S_MERGE
    } state_t;

endpackage

### rtl/slm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; used for the two point lists.
module slm_ram #(
    parameter int WIDTH  = 128,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/slm_ctrl.sv
// Load and merge sequencer: list counts, read indices and the output register.
// Depends on slm_pkg; drives the two list memories through ram_req_t.
module slm_ctrl import slm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [POINT_W-1:0]  s_tdata,   // point_key, point_value
    input  logic [REQ_W-1:0]    s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [POINT_W-1:0]  m_tdata,   // out_key, out_value
    output logic                m_tlast,
    output logic [STATUS_W-1:0] m_tuser,   // status
    input  point_t              rd_a,
    input  point_t              rd_b,
    output ram_req_t            req_a,
    output ram_req_t            req_b
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0]   idx_a_reg, idx_a_next, idx_b_reg, idx_b_next;
    logic               mv_reg, mv_next;
    point_t             md_reg, md_next;
    logic               ml_reg, ml_next;
    logic [STATUS_W-1:0] ms_reg, ms_next;

    logic   out_free, accept, a_left, b_left, take_a, last_pt, both_empty;
    point_t in_pt;

    assign out_free   = !mv_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE) && out_free;
    assign accept     = s_tvalid && s_tready;
    assign in_pt      = point_t'(s_tdata);
    assign a_left     = idx_a_reg < cnt_a_reg;
    assign b_left     = idx_b_reg < cnt_b_reg;
    assign take_a     = a_left && (!b_left || (rd_a.key <= rd_b.key));
    assign last_pt    = take_a ? ((idx_a_reg + 1'b1 == cnt_a_reg) && !b_left)
                               : ((idx_b_reg + 1'b1 == cnt_b_reg) && !a_left);
    assign both_empty = (cnt_a_reg == '0) && (cnt_b_reg == '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_tuser == REQ_MERGE) && !both_empty) begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE: begin
                if (out_free && last_pt) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        idx_a_next  = idx_a_reg;
        idx_b_next  = idx_b_reg;
        mv_next     = mv_reg && !m_tready;
        md_next     = md_reg;
        ml_next     = ml_reg;
        ms_next     = ms_reg;
        req_a.we    = 1'b0;
        req_b.we    = 1'b0;
        req_a.waddr = cnt_a_reg[IDX_W-1:0];
        req_b.waddr = cnt_b_reg[IDX_W-1:0];
        req_a.wdata = in_pt;
        req_b.wdata = in_pt;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        REQ_LOAD_A: begin
                            if (cnt_a_reg == CNT_W'(LIST_DEPTH)) begin
                                mv_next = 1'b1;
                                md_next = '0;
                                ml_next = 1'b1;
                                ms_next = ST_FULL;
                            end else begin
                                req_a.we   = 1'b1;
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                        end
                        REQ_LOAD_B: begin
                            if (cnt_b_reg == CNT_W'(LIST_DEPTH)) begin
                                mv_next = 1'b1;
                                md_next = '0;
                                ml_next = 1'b1;
                                ms_next = ST_FULL;
                            end else begin
                                req_b.we   = 1'b1;
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                        end
                        REQ_MERGE: begin
                            if (both_empty) begin
                                mv_next = 1'b1;
                                md_next = '0;
                                ml_next = 1'b1;
                                ms_next = ST_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MERGE: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = take_a ? rd_a : rd_b;
                    ml_next = last_pt;
                    ms_next = ST_POINT;
                    if (take_a) begin
                        idx_a_next = idx_a_reg + 1'b1;
                    end else begin
                        idx_b_next = idx_b_reg + 1'b1;
                    end
                    if (last_pt) begin
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        idx_a_next = '0;
                        idx_b_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        // The memories read the next head every cycle, so the data is ready next cycle.
        req_a.raddr = idx_a_next[IDX_W-1:0];
        req_b.raddr = idx_b_next[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            idx_a_reg <= '0;
            idx_b_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            idx_a_reg <= idx_a_next;
            idx_b_reg <= idx_b_next;
            mv_reg    <= mv_next;
        end
        md_reg <= md_next;
        ml_reg <= ml_next;
        ms_reg <= ms_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = ms_reg;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_a_reg <= CNT_W'(LIST_DEPTH)) && (cnt_b_reg <= CNT_W'(LIST_DEPTH)))
        else $error("list count beyond depth");
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_a_reg <= cnt_a_reg) && (idx_b_reg <= cnt_b_reg))
        else $error("merge index beyond list count");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == S_IDLE))
        else $error("input taken during a merge");
    a_clear_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE && out_free && last_pt)
        |=> (cnt_a_reg == '0) && (cnt_b_reg == '0) && m_tvalid && m_tlast)
        else $error("lists not cleared after the last merged point");
`endif

endmodule

### rtl/sorted_list_merge_top.sv
// Top level of the sorted list merge block: sequencer plus two list memories.
// Depends on slm_pkg, slm_ram and slm_ctrl.
// A load writes its list; a dropped load or empty merge gives its transfer in the next cycle.
// A merge reads the list heads through the memory read registers into the output register,
// one point per cycle unless the output stalls; input waits until the last point is out.
// Reset clears the counts, the sequencer and the output valid; list memories keep contents.
module sorted_list_merge_top import slm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [POINT_W-1:0]  s_tdata,   // point_key, point_value
    input  logic [REQ_W-1:0]    s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [POINT_W-1:0]  m_tdata,   // out_key, out_value
    output logic                m_tlast,   // is_last
    output logic [STATUS_W-1:0] m_tuser    // status
);

    ram_req_t req_a, req_b;
    point_t   rd_a, rd_b;

    slm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .rd_a     (rd_a),
        .rd_b     (rd_b),
        .req_a    (req_a),
        .req_b    (req_b)
    );

    slm_ram #(.WIDTH(POINT_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .aclk  (aclk),
        .we    (req_a.we),
        .waddr (req_a.waddr),
        .wdata (req_a.wdata),
        .raddr (req_a.raddr),
        .rdata (rd_a)
    );

    slm_ram #(.WIDTH(POINT_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .aclk  (aclk),
        .we    (req_b.we),
        .waddr (req_b.waddr),
        .wdata (req_b.wdata),
        .raddr (req_b.raddr),
        .rdata (rd_b)
    );

endmodule
